/* rtl/kil_pkg.sv */
// Package: shared constants, codes and controller/datapath types for the k-mer lookup block.
package kil_pkg;

  localparam int unsigned MER_LEN  = 8;
  localparam int unsigned ENTRIES  = 65536;
  localparam int unsigned MAX_HITS = 64;

  localparam int unsigned CODE_W   = 2 * MER_LEN;
  localparam int unsigned SLOT_W   = $clog2(ENTRIES);
  localparam int unsigned PTR_W    = SLOT_W + 1;
  localparam int unsigned HIT_W    = $clog2(MAX_HITS + 1);
  localparam int unsigned OFS_W    = 17;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned LOC_W    = 32;
  localparam int unsigned MER_W    = 32;
  localparam int unsigned ADDR_W   = 16;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  // Input transaction actions
  localparam logic [1:0] ACT_BKT   = 2'd0;
  localparam logic [1:0] ACT_ENTRY = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // Bucket bound read steps
  localparam logic [1:0] BND_S1 = 2'd0;
  localparam logic [1:0] BND_E2 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BKT_RD, ST_BKT_CAP, ST_INIT, ST_HEAD, ST_CMP, ST_FIN
  } state_t;

  typedef struct packed {
    logic       in_rdy;
    logic       start;
    logic [1:0] bnd_sel;
    logic       bnd_cap;
    logic       init_ptr;
    logic       step;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic query_acc;
    logic query_bad;
    logic loop_ok;
    logic hit;
    logic pend_vld;
    logic out_free;
  } status_t;

endpackage

/* rtl/kil_if.sv */
// Interfaces: valid/ready channels for input items and result items.
interface kil_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [15:0]               addr;
  logic [16:0]               offset_value;
  logic [15:0]               entry_genome;
  logic [31:0]               entry_location;
  logic [31:0]               query_mer;
  modport source (output valid, action, addr, offset_value, entry_genome,
                  entry_location, query_mer, input ready);
  modport sink   (input valid, action, addr, offset_value, entry_genome,
                  entry_location, query_mer, output ready);
endinterface

interface kil_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] hit_genome;
  logic [31:0] hit_location;
  logic        truncated;
  logic        last;
  modport source (output valid, found, hit_genome, hit_location, truncated, last,
                  input ready);
  modport sink   (input valid, found, hit_genome, hit_location, truncated, last,
                  output ready);
endinterface

/* rtl/kil_ctrl.sv */
// Controller: sequences bucket reads, the merge walk and result emission.
module kil_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  kil_pkg::status_t  st,
  output kil_pkg::cmd_t     cmd
);

  kil_pkg::state_t state_r, state_nxt;
  logic [1:0]      step_r, step_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kil_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      kil_pkg::ST_IDLE: begin
        step_nxt = kil_pkg::BND_S1;
        if (st.query_acc) begin
          state_nxt = st.query_bad ? kil_pkg::ST_FIN : kil_pkg::ST_BKT_RD;
        end
      end
      kil_pkg::ST_BKT_RD:  state_nxt = kil_pkg::ST_BKT_CAP;
      kil_pkg::ST_BKT_CAP: begin
        step_nxt  = step_r + 2'd1;
        state_nxt = (step_r == kil_pkg::BND_E2) ? kil_pkg::ST_INIT : kil_pkg::ST_BKT_RD;
      end
      kil_pkg::ST_INIT: state_nxt = kil_pkg::ST_HEAD;
      kil_pkg::ST_HEAD: state_nxt = st.loop_ok ? kil_pkg::ST_CMP : kil_pkg::ST_FIN;
      kil_pkg::ST_CMP: begin
        if (!(st.hit && st.pend_vld && !st.out_free)) begin
          state_nxt = kil_pkg::ST_HEAD;
        end
      end
      kil_pkg::ST_FIN: begin
        if (st.out_free) begin
          state_nxt = kil_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kil_pkg::ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd = '0;
    cmd.bnd_sel = step_r;
    case (state_r)
      kil_pkg::ST_IDLE: begin
        cmd.in_rdy = 1'b1;
        cmd.start  = st.query_acc;
      end
      kil_pkg::ST_BKT_CAP: cmd.bnd_cap  = 1'b1;
      kil_pkg::ST_INIT:    cmd.init_ptr = 1'b1;
      kil_pkg::ST_CMP:     cmd.step = !(st.hit && st.pend_vld && !st.out_free);
      kil_pkg::ST_FIN:     cmd.fin  = st.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/kil_dp.sv */
// Datapath: index tables, query decode, merge compare, pending hit and result register.
module kil_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata,
  kil_in_if.sink            in_ch,
  kil_out_if.source         out_ch,
  input  kil_pkg::cmd_t     cmd,
  output kil_pkg::status_t  st
);

  // Tables
  logic [kil_pkg::OFS_W-1:0] bkt_mem [2**kil_pkg::CODE_W];
  logic [kil_pkg::GEN_W-1:0] gen_mem [kil_pkg::ENTRIES];
  logic [kil_pkg::LOC_W-1:0] loc_mem [kil_pkg::ENTRIES];

  logic [kil_pkg::LEN_W-1:0]  ql_r;
  logic [kil_pkg::LEN_W-1:0]  gap_r;
  logic                       single_r;
  logic [kil_pkg::CODE_W-1:0] lead_r, trail_r;
  logic [kil_pkg::PTR_W-1:0]  bnd_r [4];
  logic [kil_pkg::PTR_W-1:0]  j1_r, j2_r;
  logic [kil_pkg::HIT_W-1:0]  hits_r;
  logic                       pend_vld_r;
  logic [kil_pkg::GEN_W-1:0]  pend_g_r;
  logic [kil_pkg::LOC_W-1:0]  pend_l_r;
  logic [kil_pkg::OFS_W-1:0]  bkt_rd_r;
  logic [kil_pkg::GEN_W-1:0]  g1_r, g2_r;
  logic [kil_pkg::LOC_W-1:0]  l1_r, l2_r;
  logic                       out_vld_r;
  logic                       out_found_r, out_trunc_r, out_last_r;
  logic [kil_pkg::GEN_W-1:0]  out_g_r;
  logic [kil_pkg::LOC_W-1:0]  out_l_r;

  logic                       acc;
  logic [32:0]                sh;
  logic [kil_pkg::MER_W-1:0]  mer_m;
  logic [kil_pkg::LEN_W-1:0]  gap;
  logic [kil_pkg::CODE_W-1:0] bkt_addr, code_sel;
  logic [kil_pkg::PTR_W-1:0]  bnd_val;
  logic [32:0]                want, have;
  logic                       eqg, hit, adv1, adv2, out_free;

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = cmd.in_rdy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ql_r <= kil_pkg::LEN_RESET;
    end else if (cfg_we) begin
      ql_r <= cfg_wdata;
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (acc && in_ch.action == kil_pkg::ACT_BKT) begin
      bkt_mem[in_ch.addr[kil_pkg::CODE_W-1:0]] <= in_ch.offset_value;
    end
    if (acc && in_ch.action == kil_pkg::ACT_ENTRY &&
        {1'b0, in_ch.addr} < 17'(kil_pkg::ENTRIES)) begin
      gen_mem[in_ch.addr[kil_pkg::SLOT_W-1:0]] <= in_ch.entry_genome;
      loc_mem[in_ch.addr[kil_pkg::SLOT_W-1:0]] <= in_ch.entry_location;
    end
  end

  // Query decode: mask to 2L bits, split into leading and trailing codes
  assign sh    = 33'd1 << {ql_r, 1'b0};
  assign mer_m = in_ch.query_mer & 32'(sh - 33'd1);
  assign gap   = ql_r - kil_pkg::LEN_W'(kil_pkg::MER_LEN);

  assign st.query_acc = acc && in_ch.action == kil_pkg::ACT_QUERY;
  assign st.query_bad = ql_r < kil_pkg::LEN_W'(kil_pkg::MER_LEN) ||
                        ql_r > kil_pkg::LEN_W'(2 * kil_pkg::MER_LEN) ||
                        ql_r > 5'd16;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      gap_r    <= gap;
      single_r <= (gap == '0);
      lead_r   <= kil_pkg::CODE_W'(mer_m >> {gap, 1'b0});
      trail_r  <= mer_m[kil_pkg::CODE_W-1:0];
    end
  end

  // Bucket bound reads: odd steps read the end, even steps the previous end
  assign code_sel = cmd.bnd_sel[1] ? trail_r : lead_r;
  assign bkt_addr = cmd.bnd_sel[0] ? code_sel : code_sel - 1'b1;

  always_ff @(posedge clk) begin
    bkt_rd_r <= bkt_mem[bkt_addr];
  end

  always_comb begin
    if (!cmd.bnd_sel[0] && code_sel == '0) begin
      bnd_val = '0;
    end else if (bkt_rd_r > kil_pkg::OFS_W'(kil_pkg::ENTRIES)) begin
      bnd_val = kil_pkg::PTR_W'(kil_pkg::ENTRIES);
    end else begin
      bnd_val = kil_pkg::PTR_W'(bkt_rd_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bnd_cap) begin
      bnd_r[cmd.bnd_sel] <= bnd_val;
    end
  end

  // Entry reads at both walk pointers
  always_ff @(posedge clk) begin
    g1_r <= gen_mem[j1_r[kil_pkg::SLOT_W-1:0]];
    l1_r <= loc_mem[j1_r[kil_pkg::SLOT_W-1:0]];
    g2_r <= gen_mem[j2_r[kil_pkg::SLOT_W-1:0]];
    l2_r <= loc_mem[j2_r[kil_pkg::SLOT_W-1:0]];
  end

  // Merge compare
  assign want = {1'b0, l1_r} + 33'(gap_r);
  assign have = {1'b0, l2_r};
  assign eqg  = (g1_r == g2_r);
  assign hit  = single_r || (eqg && want == have);
  assign adv1 = single_r || hit || g1_r < g2_r || (eqg && want < have);
  assign adv2 = !single_r && (hit || g1_r > g2_r || (eqg && want >= have));

  assign out_free   = !out_vld_r || out_ch.ready;
  assign st.loop_ok = j1_r < bnd_r[1] && (single_r || j2_r < bnd_r[3]) &&
                      hits_r < kil_pkg::HIT_W'(kil_pkg::MAX_HITS);
  assign st.hit      = hit;
  assign st.pend_vld = pend_vld_r;
  assign st.out_free = out_free;

  // Walk pointers, hit count and pending hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.start) begin
      hits_r     <= '0;
      pend_vld_r <= 1'b0;
    end else if (cmd.step && hit) begin
      hits_r     <= hits_r + 1'b1;
      pend_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_ptr) begin
      j1_r <= bnd_r[0];
      j2_r <= bnd_r[2];
    end else if (cmd.step) begin
      if (adv1) j1_r <= j1_r + 1'b1;
      if (adv2) j2_r <= j2_r + 1'b1;
    end
    if (cmd.step && hit) begin
      pend_g_r <= g1_r;
      pend_l_r <= l1_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if ((cmd.step && hit && pend_vld_r) || cmd.fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit && pend_vld_r) begin
      out_found_r <= 1'b1;
      out_g_r     <= pend_g_r;
      out_l_r     <= pend_l_r;
      out_trunc_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else if (cmd.fin) begin
      out_found_r <= pend_vld_r;
      out_g_r     <= pend_vld_r ? pend_g_r : '0;
      out_l_r     <= pend_vld_r ? pend_l_r : '0;
      out_trunc_r <= pend_vld_r && hits_r >= kil_pkg::HIT_W'(kil_pkg::MAX_HITS);
      out_last_r  <= 1'b1;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.hit_genome   = out_g_r;
  assign out_ch.hit_location = out_l_r;
  assign out_ch.truncated    = out_trunc_r;
  assign out_ch.last         = out_last_r;

`ifndef SYNTHESIS
  a_hits_cap: assert property (@(posedge clk) disable iff (!rst_n)
    hits_r <= kil_pkg::HIT_W'(kil_pkg::MAX_HITS))
    else $error("hit count above limit");
  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> hits_r != '0)
    else $error("pending hit with zero count");
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin || (cmd.step && hit && pend_vld_r)) |-> out_free)
    else $error("result loaded into busy output register");
`endif

endmodule

/* rtl/kmer_index_lmer_lookup.sv */
// Top level: k-mer index with L-mer lookup by merge join of two buckets.
// Channels: in_ch (valid/ready) carries table writes and queries; out_ch
// (valid/ready) carries hit results; cfg_we/cfg_wdata set query_length L.
// Action 0 writes a bucket end offset, action 1 writes an entry slot; both
// give no result. Action 2 runs a query and gives one result per hit (last
// set on the final one) or a single not-found result.
// Query sequence: accept, bucket bound reads through the single offset
// table port, a pointer load, then per merge step an entry read at both
// pointers and a compare, and last a closing loop check and a finish step.
// The walk covers at most the sum of both bucket sizes and stops after
// MAX_HITS hits. A new item is taken once the previous query has placed its
// last result in the output register. Each hit is held as pending until the
// next is found or the walk ends, so it knows whether it is last. When the
// receiver stalls, the walk pauses on the next hit until the output register
// drains. Reset clears control state and sets L to 16; table contents are
// undefined until written.
module kmer_index_lmer_lookup (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata,
  kil_in_if.sink     in_ch,
  kil_out_if.source  out_ch
);

  kil_pkg::cmd_t    cmd;
  kil_pkg::status_t st;

  kil_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  kil_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* verif/kil_lookup_checker.sv */
// Checker for the k-mer lookup block: keeps its own copy of the tables, predicts results, compares.
module kil_lookup_checker
  import kil_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  kil_in_if                in_mon,
  kil_out_if               out_mon,
  output int               errors,
  output int               pending,
  output int               n_results,
  output int               n_truncated
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             found;
    logic [GEN_W-1:0] genome;
    logic [LOC_W-1:0] location;
    logic             truncated;
    logic             last;
  } hit_t;

  // shadow tables and length register
  bit [OFS_W-1:0] end_tbl [1 << CODE_W];
  bit [GEN_W-1:0] gen_tbl [ENTRIES];
  bit [LOC_W-1:0] loc_tbl [ENTRIES];
  bit [LEN_W-1:0] qlen;
  hit_t           expected_hits [$];

  initial begin
    errors = 0;
    pending = 0;
    n_results = 0;
    n_truncated = 0;
  end

  // slot range of one bucket, clamped to the entry store
  function automatic void bucket_span(input bit [CODE_W-1:0] code,
                                      output int unsigned lo, output int unsigned hi);
    lo = (code == 0) ? 0 : end_tbl[code - 1];
    hi = end_tbl[code];
    if (lo > ENTRIES) lo = ENTRIES;
    if (hi > ENTRIES) hi = ENTRIES;
  endfunction

  // expected results of one query at the current length
  function automatic void predict_lookup(input logic [MER_W-1:0] mer_in);
    int unsigned     len, gap, s1, e1, s2, e2, j1, j2;
    longint unsigned mer, want, have;
    hit_t            found_q [$];
    hit_t            one;
    len = qlen;
    if (len >= MER_LEN && len <= 2 * MER_LEN && len <= 16) begin
      mer = longint'(mer_in) & ((64'd1 << (2 * len)) - 1);
      if (len == MER_LEN) begin
        bucket_span(mer[CODE_W-1:0], s1, e1);
        for (j1 = s1; j1 < e1 && found_q.size() < MAX_HITS; j1++) begin
          one = '{1'b1, gen_tbl[j1], loc_tbl[j1], 1'b0, 1'b0};
          found_q = {found_q, one};
        end
      end else begin
        gap = len - MER_LEN;
        bucket_span(CODE_W'(mer >> (2 * gap)), s1, e1);
        bucket_span(mer[CODE_W-1:0], s2, e2);
        j1 = s1;
        j2 = s2;
        // merge join on (genome, location), leading side shifted by the gap
        while (j1 < e1 && j2 < e2 && found_q.size() < MAX_HITS) begin
          want = longint'(loc_tbl[j1]) + gap;
          have = longint'(loc_tbl[j2]);
          if (gen_tbl[j1] == gen_tbl[j2] && want == have) begin
            one = '{1'b1, gen_tbl[j1], loc_tbl[j1], 1'b0, 1'b0};
            found_q = {found_q, one};
            j1++;
            j2++;
          end else if (gen_tbl[j1] < gen_tbl[j2]) j1++;
          else if (gen_tbl[j1] > gen_tbl[j2]) j2++;
          else if (want < have) j1++;
          else j2++;
        end
      end
    end
    if (found_q.size() == 0) begin
      one = '{1'b0, '0, '0, 1'b0, 1'b1};
      found_q = {found_q, one};
    end else begin
      found_q[found_q.size() - 1].last = 1'b1;
      if (found_q.size() >= MAX_HITS) found_q[found_q.size() - 1].truncated = 1'b1;
    end
    expected_hits = {expected_hits, found_q};
  endfunction

  always @(posedge clk) begin
    hit_t got, exp_hit;
    if (!rst_n) begin
      qlen = LEN_RESET;
      expected_hits.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.found, out_mon.hit_genome, out_mon.hit_location,
                out_mon.truncated, out_mon.last};
        n_results++;
        if (got.truncated) n_truncated++;
        if (expected_hits.size() == 0) begin
          errors++;
          $display("%0t: unexpected result found=%0b genome=%h loc=%h trunc=%0b last=%0b",
                   $time, got.found, got.genome, got.location, got.truncated, got.last);
        end else begin
          exp_hit = expected_hits.pop_front();
          if (got.found !== exp_hit.found || got.genome !== exp_hit.genome ||
              got.location !== exp_hit.location || got.truncated !== exp_hit.truncated ||
              got.last !== exp_hit.last) begin
            errors++;
            $display("%0t: mismatch expected found=%0b genome=%h loc=%h trunc=%0b last=%0b",
                     $time, exp_hit.found, exp_hit.genome, exp_hit.location,
                     exp_hit.truncated, exp_hit.last);
            $display("%0t:          actual   found=%0b genome=%h loc=%h trunc=%0b last=%0b",
                     $time, got.found, got.genome, got.location, got.truncated, got.last);
          end
        end
      end
      if (cfg_we) qlen = cfg_wdata;
      // input transaction updates tables or queues a prediction
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_BKT:   end_tbl[in_mon.addr] = in_mon.offset_value;
          ACT_ENTRY: begin
            gen_tbl[in_mon.addr] = in_mon.entry_genome;
            loc_tbl[in_mon.addr] = in_mon.entry_location;
          end
          ACT_QUERY: predict_lookup(in_mon.query_mer);
          default: ;
        endcase
      end
    end
    pending = expected_hits.size();
  end

endmodule

/* verif/tb_kmer_index_lmer_lookup.sv */
// Testbench top: clock, reset, table loads and queries, idling, verdict.
module tb_kmer_index_lmer_lookup;
  import kil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_NOP = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int QUIET_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int TARGET_ITEMS = 360;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int               errors, pending, n_results, n_truncated;
  int               n_items, n_queries, idle_run, hold_left;
  int               in_idle_pct, out_idle_pct;
  bit               stall_req;
  bit [47:0]        bucket_rec [int][$];

  kil_in_if  in_ch ();
  kil_out_if out_ch ();

  kmer_index_lmer_lookup dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  kil_lookup_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .errors     (errors),
    .pending    (pending),
    .n_results  (n_results),
    .n_truncated(n_truncated)
  );

  always #5 clk = ~clk;

  // receiver: random ready, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_req) begin
        hold_left = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_run = 0;
      end else if (++idle_run >= STALL_LIMIT) begin
        $display("tb_kmer_index_lmer_lookup: done, errors");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [15:0] a,
                           input logic [16:0] ofs, input logic [15:0] g,
                           input logic [31:0] loc, input logic [31:0] mer);
    // idle profile follows progress through the run
    if (n_items < TARGET_ITEMS / 3) begin
      in_idle_pct = 37;
      out_idle_pct = 85;
    end else if (n_items < 2 * TARGET_ITEMS / 3) begin
      in_idle_pct = 85;
      out_idle_pct = 37;
    end else begin
      in_idle_pct = 0;
      out_idle_pct = 0;
    end
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.action         <= act;
    in_ch.addr           <= a;
    in_ch.offset_value   <= ofs;
    in_ch.entry_genome   <= g;
    in_ch.entry_location <= loc;
    in_ch.query_mer      <= mer;
    do @(posedge clk); while (!in_ch.ready);
    if (act != ACT_NOP) n_items++;
    if (act == ACT_QUERY) n_queries++;
  endtask

  task automatic write_offset(input int code, input int value);
    send_item(ACT_BKT, 16'(code), 17'(value), 16'($urandom), $urandom, $urandom);
  endtask

  task automatic write_entry(input int slot, input logic [15:0] g, input logic [31:0] loc);
    send_item(ACT_ENTRY, 16'(slot), 17'($urandom), g, loc, $urandom);
  endtask

  task automatic lookup(input logic [31:0] mer);
    send_item(ACT_QUERY, 16'($urandom), 17'($urandom), 16'($urandom), $urandom, mer);
  endtask

  // drain, let the block settle, then write the length register
  task automatic set_length(input int len);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LEN_W'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic bit [47:0] random_rec();
    logic [15:0] g;
    logic [31:0] loc;
    g   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    loc = ($urandom_range(5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3) : $urandom;
    return {g, loc};
  endfunction

  // one phase: pick query mers, build consistent buckets, load them, then query
  task automatic run_phase(input int len, input bit big, input int n_mers, input bit squeeze);
    logic [31:0]     mers [$];
    bit [47:0]       recs [$];
    bit [47:0]       src [$];
    bit [47:0]       rec;
    longint unsigned mm;
    logic [31:0]     m;
    int              gap, lead, trail, cur, s, prev, n_entries;
    set_length(len);
    if (len < MER_LEN || len > 2 * MER_LEN) begin
      repeat (n_mers) lookup($urandom);
      return;
    end
    gap = len - MER_LEN;
    bucket_rec.delete();
    for (int i = 0; i < n_mers; i++) begin
      m = $urandom;
      mers = {mers, m};
      mm    = longint'(m) & ((64'd1 << (2 * len)) - 1);
      lead  = int'(mm >> (2 * gap)) & 16'hFFFF;
      trail = int'(mm & 64'hFFFF);
      if (!bucket_rec.exists(lead)) begin
        recs = {};
        n_entries = (big && i == 0) ? MAX_HITS + 2 : $urandom_range(0, 4);
        repeat (n_entries) recs = {recs, random_rec()};
        if (big || $urandom_range(7) != 0) recs.sort();
        bucket_rec[lead] = recs;
      end
      // trailing bucket mostly mirrors the leading one shifted by the gap
      if (gap != 0 && !bucket_rec.exists(trail)) begin
        recs = {};
        src = bucket_rec[lead];
        foreach (src[k]) begin
          rec = src[k];
          if (big || $urandom_range(3) != 0) begin
            rec = {rec[47:32], rec[31:0] + 32'(gap)};
            recs = {recs, rec};
          end
        end
        repeat ($urandom_range(0, 2)) recs = {recs, random_rec()};
        if (big || $urandom_range(7) != 0) recs.sort();
        bucket_rec[trail] = recs;
      end
    end
    // load buckets in code order so end offsets stay cumulative
    cur = 0;
    prev = -2;
    foreach (bucket_rec[c]) begin
      if (c == 0) begin
        s = 0;
      end else if (prev == c - 1) begin
        s = cur;
      end else begin
        write_offset(c - 1, cur);
        s = cur;
      end
      src = bucket_rec[c];
      foreach (src[k]) write_entry(s + k, src[k][47:32], src[k][31:0]);
      cur = s + src.size();
      write_offset(c, cur);
      prev = c;
    end
    if (squeeze) stall_req = 1'b1;
    repeat (3 * n_mers) begin
      m = mers[$urandom_range(mers.size() - 1)];
      if (len < 16) m = m | ($urandom << (2 * len));
      lookup(m);
    end
  endtask

  initial begin
    int lens [13] = '{8, 12, 16, 9, 20, 8, 14, 10, 13, 11, 15, 16, 0};
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NOP;
    in_ch.addr = '0;
    in_ch.offset_value = '0;
    in_ch.entry_genome = '0;
    in_ch.entry_location = '0;
    in_ch.query_mer = '0;
    out_ch.ready = 1'b0;
    n_items = 0;
    n_queries = 0;
    idle_run = 0;
    hold_left = 0;
    stall_req = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: lowest and highest codes and slots, clamped and empty buckets
    set_length(MER_LEN);
    write_offset(0, 2);
    write_entry(0, 16'h0000, 32'h0000_0000);
    write_entry(1, 16'hFFFF, 32'hFFFF_FFFF);
    lookup(32'hFFFF_0000);
    write_offset(16'h7FFF, 17'h1_0000);
    write_offset(16'h8000, 5);
    lookup(32'h0000_8000);
    write_offset(16'hFFFE, 65534);
    write_offset(16'hFFFF, 17'h1_0000);
    write_entry(65534, 16'h5555, 32'hAAAA_AAAA);
    write_entry(65535, 16'hAAAA, 32'h5555_5555);
    lookup(32'hFFFF_FFFF);
    send_item(ACT_NOP, 16'($urandom), 17'($urandom), 16'($urandom), $urandom, $urandom);
    // location sum past 32 bits must not match
    set_length(MER_LEN + 1);
    lookup(32'h0000_0000);
    // lengths out of range give a single not-found
    set_length(0);
    lookup(32'h0000_0000);
    set_length(MER_LEN - 1);
    lookup(32'h0000_0000);
    set_length(2 * MER_LEN + 1);
    lookup(32'hFFFF_FFFF);
    set_length(31);
    lookup(32'hFFFF_FFFF);
    set_length(2 * MER_LEN);
    lookup(32'hFFFF_FFFF);

    // random phases, big buckets to reach the hit limit, one receiver hold-off
    foreach (lens[i]) run_phase(lens[i], i == 0 || i == 2, 3, i == 3);
    while (n_items < TARGET_ITEMS) run_phase($urandom_range(MER_LEN, 2 * MER_LEN), 0, 3, 0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    $display("covered %0d table writes and queries (%0d queries), %0d results, %0d truncated",
             n_items, n_queries, n_results, n_truncated);
    $display("lengths 0 to 31 incl. out-of-range, clamped bounds, hit limit, receiver hold-off");
    if (errors == 0) begin
      $display("tb_kmer_index_lmer_lookup: done, clean");
    end else begin
      $display("tb_kmer_index_lmer_lookup: done, errors");
    end
    $finish;
  end

endmodule
